@@ rtl/mvas_pkg.sv @@
// Shared types, constants and the arctangent table for the mesh vertex angle-sum block.
// Depends on nothing; mvas_corner_angle and the top level in rtl import it.
package mvas_pkg;

    localparam int MAX_POINTS_DEFAULT = 4096;
    localparam int INDEX_W            = 12;
    localparam int COORD_W            = 24;
    localparam int SUM_W              = 32;
    localparam int ANGLE_Z_W          = 28;
    localparam int CORDIC_STEPS       = 24;
    localparam int SQRT_STEPS         = 32;

    localparam logic [SUM_W-1:0]         THRESHOLD_RESET = 32'd79060768;
    localparam logic [ANGLE_Z_W-1:0]     PI_Q24          = 28'd52707179;
    localparam logic [ANGLE_Z_W-1:0]     HALF_PI_Q24     = 28'd26353589;

    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_FACE  = 2'd1;
    localparam logic [1:0] KIND_QUERY = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
    } coord_t;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } vec3_t;

    // atan(2^-i) in Q0.24, rounded.
    function automatic logic [23:0] atan_q24(input logic [4:0] i);
        logic [23:0] t;
        unique case (i)
            5'd0:  t = 24'd13176795;
            5'd1:  t = 24'd7778716;
            5'd2:  t = 24'd4110060;
            5'd3:  t = 24'd2086331;
            5'd4:  t = 24'd1047214;
            5'd5:  t = 24'd524117;
            5'd6:  t = 24'd262123;
            5'd7:  t = 24'd131069;
            5'd8:  t = 24'd65536;
            5'd9:  t = 24'd32768;
            5'd10: t = 24'd16384;
            5'd11: t = 24'd8192;
            5'd12: t = 24'd4096;
            5'd13: t = 24'd2048;
            5'd14: t = 24'd1024;
            5'd15: t = 24'd512;
            5'd16: t = 24'd256;
            5'd17: t = 24'd128;
            5'd18: t = 24'd64;
            5'd19: t = 24'd32;
            5'd20: t = 24'd16;
            5'd21: t = 24'd8;
            5'd22: t = 24'd4;
            5'd23: t = 24'd2;
            default: t = 24'd0;
        endcase
        return t;
    endfunction

endpackage

@@ rtl/mvas_ram.sv @@
// Generic single-clock RAM: one write port, one read port with registered read data.
// Depends on nothing.
module mvas_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule

@@ rtl/mvas_corner_angle.sv @@
// Corner angle unit: dot and cross products, iterative square root and CORDIC atan2.
// Depends on mvas_pkg.
module mvas_corner_angle (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  mvas_pkg::vec3_t u,
    input  mvas_pkg::vec3_t w,
    output logic          done,
    output logic [31:0]   angle
);
    import mvas_pkg::*;

    typedef enum logic [6:0] {
        A_IDLE = 7'b0000001,
        A_PROD = 7'b0000010,
        A_SQ   = 7'b0000100,
        A_SQRT = 7'b0001000,
        A_INIT = 7'b0010000,
        A_ROT  = 7'b0100000,
        A_FIN  = 7'b1000000
    } astate_t;

    astate_t state_reg, state_next;
    vec3_t u_reg, u_next, w_reg, w_next;
    logic signed [33:0] dot_reg, dot_next;
    logic signed [31:0] cross_reg [3];
    logic signed [31:0] cross_next [3];
    logic [63:0] acc_reg, acc_next;
    logic [63:0] res_reg, res_next;
    logic [63:0] bit_reg, bit_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic signed [35:0] x_reg, x_next, y_reg, y_next;
    logic signed [ANGLE_Z_W-1:0] z_reg, z_next;
    logic [31:0] angle_reg, angle_next;
    logic done_reg, done_next;

    logic signed [31:0] pxx, pyy, pzz, pyz, pzy, pzx, pxz, pxy, pyx;
    logic [30:0] cmag;
    logic [61:0] csq;
    logic [63:0] trial;
    logic signed [35:0] xs, ys;
    logic signed [ANGLE_Z_W-1:0] tz;

    always_comb begin
        pxx = u_reg.x * w_reg.x;
        pyy = u_reg.y * w_reg.y;
        pzz = u_reg.z * w_reg.z;
        pyz = u_reg.y * w_reg.z;
        pzy = u_reg.z * w_reg.y;
        pzx = u_reg.z * w_reg.x;
        pxz = u_reg.x * w_reg.z;
        pxy = u_reg.x * w_reg.y;
        pyx = u_reg.y * w_reg.x;
        cmag = cross_reg[cnt_reg[1:0]][31] ? 31'(-cross_reg[cnt_reg[1:0]])
                                           : 31'(cross_reg[cnt_reg[1:0]]);
        csq   = cmag * cmag;
        trial = res_reg + bit_reg;
        xs = x_reg >>> cnt_reg[4:0];
        ys = y_reg >>> cnt_reg[4:0];
        tz = ANGLE_Z_W'(atan_q24(cnt_reg[4:0]));
    end

    always_comb begin
        state_next = state_reg;
        u_next = u_reg;
        w_next = w_reg;
        dot_next = dot_reg;
        cross_next = cross_reg;
        acc_next = acc_reg;
        res_next = res_reg;
        bit_next = bit_reg;
        cnt_next = cnt_reg;
        x_next = x_reg;
        y_next = y_reg;
        z_next = z_reg;
        angle_next = angle_reg;
        done_next = 1'b0;
        unique case (state_reg)
            A_IDLE: begin
                if (start) begin
                    u_next = u;
                    w_next = w;
                    state_next = A_PROD;
                end
            end
            A_PROD: begin
                dot_next = 34'(pxx) + 34'(pyy) + 34'(pzz);
                cross_next[0] = pyz - pzy;
                cross_next[1] = pzx - pxz;
                cross_next[2] = pxy - pyx;
                acc_next = '0;
                cnt_next = '0;
                state_next = A_SQ;
            end
            A_SQ: begin
                acc_next = acc_reg + 64'(csq);
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd2) begin
                    res_next = '0;
                    bit_next = 64'd1 << 62;
                    cnt_next = '0;
                    state_next = A_SQRT;
                end
            end
            A_SQRT: begin
                // One root bit per cycle, restoring method.
                if (acc_reg >= trial) begin
                    acc_next = acc_reg - trial;
                    res_next = (res_reg >> 1) + bit_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                bit_next = bit_reg >> 2;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(SQRT_STEPS - 1)) begin
                    state_next = A_INIT;
                end
            end
            A_INIT: begin
                // An obtuse corner is turned by a quarter turn first.
                if (dot_reg < 0) begin
                    x_next = $signed({3'b000, res_reg[32:0]});
                    y_next = -36'(dot_reg);
                    z_next = HALF_PI_Q24;
                end else begin
                    x_next = 36'(dot_reg);
                    y_next = $signed({3'b000, res_reg[32:0]});
                    z_next = '0;
                end
                cnt_next = '0;
                state_next = A_ROT;
            end
            A_ROT: begin
                if (y_reg > 0) begin
                    x_next = x_reg + ys;
                    y_next = y_reg - xs;
                    z_next = z_reg + tz;
                end else begin
                    x_next = x_reg - ys;
                    y_next = y_reg + xs;
                    z_next = z_reg - tz;
                end
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'(CORDIC_STEPS - 1)) begin
                    state_next = A_FIN;
                end
            end
            A_FIN: begin
                if (z_reg < 0) begin
                    angle_next = '0;
                end else if (z_reg > $signed(PI_Q24)) begin
                    angle_next = 32'(PI_Q24);
                end else begin
                    angle_next = 32'(unsigned'(z_reg));
                end
                done_next = 1'b1;
                state_next = A_IDLE;
            end
            default: state_next = A_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= A_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        u_reg <= u_next;
        w_reg <= w_next;
        dot_reg <= dot_next;
        cross_reg <= cross_next;
        acc_reg <= acc_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
        cnt_reg <= cnt_next;
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
        angle_reg <= angle_next;
    end

    assign done  = done_reg;
    assign angle = angle_reg;
endmodule

@@ rtl/mesh_vertex_angle_sum_edge_detect.sv @@
// Top level of the mesh vertex angle-sum edge detector: sequencer, side normalisation,
// point stores and result register. Depends on mvas_pkg, mvas_ram and mvas_corner_angle.

// The block keeps the coordinates and the running interior-angle sum of up to MAX_POINTS
// points in two single-port-read RAMs. After reset it first clears the angle-sum RAM, one
// entry a cycle, during which no input transfer is taken (the threshold register may
// still be written). Items are then handled one at a time. A load writes the point and
// clears its sum in the dispatch state; a query waits for the registered sum RAM read.
// A face takes three coordinate reads, a subtraction state and a normalisation state, and
// for each of its three corners a pass through the shared angle unit (products, three
// squares, a 32-step square root and a 24-step CORDIC rotation) between a start state and
// a read-modify-write of that corner's sum. Every item gives exactly one result transfer;
// a finished result is held in the output register, and the next item is taken as soon
// as the previous result has been moved there, so a stalled result holds up the next item.
module mesh_vertex_angle_sum_edge_detect #(
    parameter int MAX_POINTS = mvas_pkg::MAX_POINTS_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [11:0] s_point_index,
    input  logic signed [23:0] s_coord_x,
    input  logic signed [23:0] s_coord_y,
    input  logic signed [23:0] s_coord_z,
    input  logic [11:0] s_vertex_a,
    input  logic [11:0] s_vertex_b,
    input  logic [11:0] s_vertex_c,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_angle_sum,
    output logic        m_is_edge,
    output logic        m_degenerate
);
    import mvas_pkg::*;

    localparam int AW = $clog2(MAX_POINTS);

    typedef enum logic [10:0] {
        S_CLEAR    = 11'b00000000001,
        S_IDLE     = 11'b00000000010,
        S_DISPATCH = 11'b00000000100,
        S_RD_A     = 11'b00000001000,
        S_RD_B     = 11'b00000010000,
        S_RD_C     = 11'b00000100000,
        S_NORM     = 11'b00001000000,
        S_ASTART   = 11'b00010000000,
        S_AWAIT    = 11'b00100000000,
        S_AWRITE   = 11'b01000000000,
        S_RESULT   = 11'b10000000000
    } state_t;

    typedef struct packed {
        logic signed [24:0] x;
        logic signed [24:0] y;
        logic signed [24:0] z;
    } side_t;

    typedef struct packed {
        logic  zero;
        vec3_t v;
    } norm_t;

    function automatic logic signed [24:0] diff24(input logic signed [23:0] p,
                                                  input logic signed [23:0] q);
        return 25'(p) - 25'(q);
    endfunction

    function automatic side_t side_of(input coord_t p, input coord_t q);
        side_t s;
        s.x = diff24(p.x, q.x);
        s.y = diff24(p.y, q.y);
        s.z = diff24(p.z, q.z);
        return s;
    endfunction

    function automatic logic [24:0] mag25(input logic signed [24:0] d);
        return d[24] ? 25'(-d) : 25'(d);
    endfunction

    function automatic logic signed [15:0] scale1(input logic signed [24:0] d,
                                                  input logic [4:0] p);
        logic [24:0] sh;
        logic [15:0] v;
        // Shift down (truncating) or shift up, so the largest lands in [2^14, 2^15).
        sh = (p >= 5'd14) ? (mag25(d) >> (p - 5'd14)) : (mag25(d) << (5'd14 - p));
        v  = {1'b0, sh[14:0]};
        return d[24] ? -$signed(v) : $signed(v);
    endfunction

    function automatic norm_t normalise(input side_t d);
        norm_t n;
        logic [24:0] m;
        logic [4:0]  p;
        m = mag25(d.x);
        if (mag25(d.y) > m) m = mag25(d.y);
        if (mag25(d.z) > m) m = mag25(d.z);
        p = '0;
        for (int k = 0; k < 25; k++) begin
            if (m[k]) p = 5'(k);
        end
        n.zero = (m == '0);
        n.v.x = scale1(d.x, p);
        n.v.y = scale1(d.y, p);
        n.v.z = scale1(d.z, p);
        return n;
    endfunction

    function automatic vec3_t neg3(input vec3_t a);
        vec3_t r;
        r.x = -a.x;
        r.y = -a.y;
        r.z = -a.z;
        return r;
    endfunction

    function automatic logic idx_ok(input logic [11:0] i);
        return 32'(i) < 32'(MAX_POINTS);
    endfunction

    state_t state_reg, state_next;
    logic [AW-1:0] clr_reg, clr_next;
    logic [1:0]  kind_reg, kind_next;
    logic [11:0] idx_reg, idx_next, va_reg, va_next, vb_reg, vb_next, vc_reg, vc_next;
    coord_t crd_reg, crd_next, pa_reg, pa_next, pb_reg, pb_next;
    side_t  e1_reg, e1_next, e2_reg, e2_next, e3_reg, e3_next;
    vec3_t  n1_reg, n1_next, n2_reg, n2_next, n3_reg, n3_next;
    logic [1:0]  corner_reg, corner_next;
    logic [31:0] ang_reg, ang_next;
    logic [31:0] res_sum_reg, res_sum_next;
    logic res_edge_reg, res_edge_next, res_deg_reg, res_deg_next;
    logic m_valid_reg, m_valid_next;
    logic [31:0] m_sum_reg, m_sum_next;
    logic m_edge_reg, m_edge_next, m_deg_reg, m_deg_next;
    logic [31:0] thr_reg, thr_next;

    logic          crd_we, crd_re, ang_we, ang_re;
    logic [AW-1:0] crd_wa, crd_ra, ang_wa, ang_ra;
    logic [71:0]   crd_rd;
    logic [31:0]   ang_wd, ang_rd;
    logic          au_start, au_done;
    logic [31:0]   au_angle;
    vec3_t         au_u, au_w;
    norm_t         nm1, nm2, nm3;
    logic [32:0]   sat_sum;
    logic [11:0]   corner_idx;

    mvas_ram #(.WIDTH(72), .DEPTH(MAX_POINTS)) u_coord_ram (
        .clk(aclk), .wr_en(crd_we), .wr_addr(crd_wa), .wr_data(crd_reg),
        .rd_en(crd_re), .rd_addr(crd_ra), .rd_data(crd_rd)
    );

    mvas_ram #(.WIDTH(32), .DEPTH(MAX_POINTS)) u_sum_ram (
        .clk(aclk), .wr_en(ang_we), .wr_addr(ang_wa), .wr_data(ang_wd),
        .rd_en(ang_re), .rd_addr(ang_ra), .rd_data(ang_rd)
    );

    mvas_corner_angle u_angle (
        .aclk(aclk), .aresetn(aresetn), .start(au_start), .u(au_u), .w(au_w),
        .done(au_done), .angle(au_angle)
    );

    assign nm1 = normalise(e1_reg);
    assign nm2 = normalise(e2_reg);
    assign nm3 = normalise(e3_reg);
    assign sat_sum = 33'(ang_rd) + 33'(ang_reg);

    always_comb begin
        unique case (corner_reg)
            2'd0: begin
                au_u = n1_reg;
                au_w = n2_reg;
                corner_idx = va_reg;
            end
            2'd1: begin
                au_u = neg3(n1_reg);
                au_w = n3_reg;
                corner_idx = vb_reg;
            end
            default: begin
                au_u = neg3(n2_reg);
                au_w = neg3(n3_reg);
                corner_idx = vc_reg;
            end
        endcase
    end

    assign s_ready = (state_reg == S_IDLE);

    always_comb begin
        state_next = state_reg;
        clr_next = clr_reg;
        kind_next = kind_reg;
        idx_next = idx_reg;
        va_next = va_reg;
        vb_next = vb_reg;
        vc_next = vc_reg;
        crd_next = crd_reg;
        pa_next = pa_reg;
        pb_next = pb_reg;
        e1_next = e1_reg;
        e2_next = e2_reg;
        e3_next = e3_reg;
        n1_next = n1_reg;
        n2_next = n2_reg;
        n3_next = n3_reg;
        corner_next = corner_reg;
        ang_next = ang_reg;
        res_sum_next = res_sum_reg;
        res_edge_next = res_edge_reg;
        res_deg_next = res_deg_reg;
        m_sum_next = m_sum_reg;
        m_edge_next = m_edge_reg;
        m_deg_next = m_deg_reg;
        m_valid_next = m_valid_reg && !m_ready;
        thr_next = cfg_we ? cfg_wdata : thr_reg;

        crd_we = 1'b0;
        crd_wa = AW'(idx_reg);
        crd_re = 1'b0;
        crd_ra = AW'(va_reg);
        ang_we = 1'b0;
        ang_wa = AW'(idx_reg);
        ang_wd = '0;
        ang_re = 1'b0;
        ang_ra = AW'(idx_reg);
        au_start = 1'b0;

        unique case (state_reg)
            S_CLEAR: begin
                ang_we = 1'b1;
                ang_wa = clr_reg;
                clr_next = clr_reg + AW'(1);
                if (clr_reg == AW'(MAX_POINTS - 1)) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    kind_next = s_kind;
                    idx_next = s_point_index;
                    va_next = s_vertex_a;
                    vb_next = s_vertex_b;
                    vc_next = s_vertex_c;
                    crd_next = '{x: s_coord_x, y: s_coord_y, z: s_coord_z};
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                res_sum_next = '0;
                res_edge_next = 1'b0;
                res_deg_next = 1'b0;
                state_next = S_RESULT;
                unique case (kind_reg)
                    KIND_LOAD: begin
                        // A load also restarts that point's angle sum.
                        crd_we = idx_ok(idx_reg);
                        ang_we = idx_ok(idx_reg);
                    end
                    KIND_FACE: begin
                        if (idx_ok(va_reg) && idx_ok(vb_reg) && idx_ok(vc_reg)) begin
                            crd_re = 1'b1;
                            crd_ra = AW'(va_reg);
                            state_next = S_RD_A;
                        end else begin
                            res_deg_next = 1'b1;
                        end
                    end
                    KIND_QUERY: begin
                        if (idx_ok(idx_reg)) begin
                            ang_re = 1'b1;
                            ang_ra = AW'(idx_reg);
                            corner_next = 2'd3;
                            state_next = S_AWRITE;
                        end
                    end
                    KIND_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end
            S_RD_A: begin
                pa_next = crd_rd;
                crd_re = 1'b1;
                crd_ra = AW'(vb_reg);
                state_next = S_RD_B;
            end
            S_RD_B: begin
                pb_next = crd_rd;
                crd_re = 1'b1;
                crd_ra = AW'(vc_reg);
                state_next = S_RD_C;
            end
            S_RD_C: begin
                e1_next = side_of(pb_reg, pa_reg);
                e2_next = side_of(crd_rd, pa_reg);
                e3_next = side_of(crd_rd, pb_reg);
                state_next = S_NORM;
            end
            S_NORM: begin
                n1_next = nm1.v;
                n2_next = nm2.v;
                n3_next = nm3.v;
                corner_next = 2'd0;
                if (nm1.zero || nm2.zero || nm3.zero) begin
                    res_deg_next = 1'b1;
                    state_next = S_RESULT;
                end else begin
                    state_next = S_ASTART;
                end
            end
            S_ASTART: begin
                au_start = 1'b1;
                state_next = S_AWAIT;
            end
            S_AWAIT: begin
                if (au_done) begin
                    ang_next = au_angle;
                    ang_re = 1'b1;
                    ang_ra = AW'(corner_idx);
                    state_next = S_AWRITE;
                end
            end
            S_AWRITE: begin
                if (corner_reg == 2'd3) begin
                    // Query read back: the sum arrives here.
                    res_sum_next = ang_rd;
                    res_edge_next = ang_rd < thr_reg;
                    state_next = S_RESULT;
                end else begin
                    // Each corner's write lands before the next corner reads, so
                    // repeated corner indices need no forwarding.
                    ang_we = 1'b1;
                    ang_wa = AW'(corner_idx);
                    ang_wd = sat_sum[32] ? 32'hFFFF_FFFF : sat_sum[31:0];
                    corner_next = corner_reg + 2'd1;
                    state_next = (corner_reg == 2'd2) ? S_RESULT : S_ASTART;
                end
            end
            S_RESULT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_sum_next = res_sum_reg;
                    m_edge_next = res_edge_reg;
                    m_deg_next = res_deg_reg;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_CLEAR;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_CLEAR;
            clr_reg <= '0;
            m_valid_reg <= 1'b0;
            thr_reg <= THRESHOLD_RESET;
        end else begin
            state_reg <= state_next;
            clr_reg <= clr_next;
            m_valid_reg <= m_valid_next;
            thr_reg <= thr_next;
        end
        kind_reg <= kind_next;
        idx_reg <= idx_next;
        va_reg <= va_next;
        vb_reg <= vb_next;
        vc_reg <= vc_next;
        crd_reg <= crd_next;
        pa_reg <= pa_next;
        pb_reg <= pb_next;
        e1_reg <= e1_next;
        e2_reg <= e2_next;
        e3_reg <= e3_next;
        n1_reg <= n1_next;
        n2_reg <= n2_next;
        n3_reg <= n3_next;
        corner_reg <= corner_next;
        ang_reg <= ang_next;
        res_sum_reg <= res_sum_next;
        res_edge_reg <= res_edge_next;
        res_deg_reg <= res_deg_next;
        m_sum_reg <= m_sum_next;
        m_edge_reg <= m_edge_next;
        m_deg_reg <= m_deg_next;
    end

    assign m_valid = m_valid_reg;
    assign m_angle_sum = m_sum_reg;
    assign m_is_edge = m_edge_reg;
    assign m_degenerate = m_deg_reg;

    // A degenerate face never carries a sum or an edge flag.
    a_deg_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_degenerate |-> !m_is_edge && m_angle_sum == '0)
        else $error("degenerate result carries a sum or edge flag");

    // A result flagged as an edge point carries a sum below the threshold.
    a_edge_thr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_is_edge |-> m_angle_sum < thr_reg)
        else $error("edge flag with sum not below threshold");

    // The angle unit never hands back more than pi.
    a_angle_clamp: assert property (@(posedge aclk) disable iff (!aresetn)
        au_done |-> au_angle <= 32'(PI_Q24))
        else $error("corner angle above pi");

    // No transfer is taken while the sum store is being cleared.
    a_clear_block: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |-> !s_ready && !au_start)
        else $error("input taken during clearing pass");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the mesh vertex angle-sum edge detector.
// It needs mvas_pkg and the block's RTL. Directed rows run first, then random phases, each
// under its own threshold; a result is checked against its typed row or the built-in predictor.
`timescale 1ns / 100ps

module testbench;
    import mvas_pkg::*;

    localparam int NPTS = 4096;

    // Fixed-point constants for the angle arithmetic, in Q8.24 radians.
    localparam longint PI_FIX      = 52707179;
    localparam longint HALF_PI_FIX = 26353589;

    logic               aclk;
    logic               aresetn;
    logic               cfg_we;
    logic [31:0]        cfg_wdata;
    logic               s_valid;
    logic               s_ready;
    logic [1:0]         s_kind;
    logic [11:0]        s_point_index;
    logic signed [23:0] s_coord_x;
    logic signed [23:0] s_coord_y;
    logic signed [23:0] s_coord_z;
    logic [11:0]        s_vertex_a;
    logic [11:0]        s_vertex_b;
    logic [11:0]        s_vertex_c;
    logic               m_valid;
    logic               m_ready;
    logic [31:0]        m_angle_sum;
    logic               m_is_edge;
    logic               m_degenerate;

    mesh_vertex_angle_sum_edge_detect dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_kind(s_kind),
        .s_point_index(s_point_index),
        .s_coord_x(s_coord_x), .s_coord_y(s_coord_y), .s_coord_z(s_coord_z),
        .s_vertex_a(s_vertex_a), .s_vertex_b(s_vertex_b), .s_vertex_c(s_vertex_c),
        .m_valid(m_valid), .m_ready(m_ready), .m_angle_sum(m_angle_sum),
        .m_is_edge(m_is_edge), .m_degenerate(m_degenerate)
    );

    typedef struct {
        logic [31:0] angle_sum;
        bit          is_edge;
        bit          degenerate;
    } outcome_t;

    // A row of the directed table. Where fixed is set, the outcome typed in the row is
    // what the block must return; otherwise the predictor supplies it.
    typedef struct {
        logic [1:0]         kind;
        logic [11:0]        idx;
        logic signed [23:0] x, y, z;
        logic [11:0]        a, b, c;
        bit                 fixed;
        outcome_t           want;
    } stim_row_t;

    typedef struct {
        bit       fixed;
        outcome_t want;
    } typed_t;

    // The predictor's copy of the block's state.
    longint      point_xyz [NPTS][3];
    logic [31:0] corner_sums [NPTS];
    logic [31:0] threshold;
    bit          loaded [NPTS];
    int          loaded_list [$];

    outcome_t    pending_results [$];
    typed_t      typed_rows [$];
    int          error_count;
    bit          idling_on;

    // The atan(2^-i) table in Q8.24, held here as integers for the rotation.
    longint rot_angle [24] = '{13176795, 7778716, 4110060, 2086331, 1047214, 524117,
        262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128,
        64, 32, 16, 8, 4, 2};

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv >>= 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res >>= 1;
            end
            bitv >>= 2;
        end
        return res;
    endfunction

    // Block normalisation of a side: the largest magnitude is brought into [2^14, 2^15).
    function automatic bit scale_side(input longint d0, d1, d2,
                                      output longint o0, o1, o2);
        longint unsigned mag [3];
        longint          d [3];
        longint          o [3];
        longint unsigned m;
        int              r, l;
        d = '{d0, d1, d2};
        m = 0;
        r = 0;
        l = 0;
        for (int i = 0; i < 3; i++) begin
            mag[i] = d[i] < 0 ? -d[i] : d[i];
            if (mag[i] > m) m = mag[i];
        end
        if (m == 0) return 0;
        while ((m >> r) >= 32768) r++;
        while (((m >> r) << l) < 16384) l++;
        for (int i = 0; i < 3; i++) begin
            o[i] = longint'((mag[i] >> r) << l);
            if (d[i] < 0) o[i] = -o[i];
        end
        o0 = o[0];
        o1 = o[1];
        o2 = o[2];
        return 1;
    endfunction

    // Interior angle between two normalised sides by CORDIC vectoring on (dot, |cross|).
    function automatic logic [31:0] interior_angle(input longint u0, u1, u2,
                                                   input longint w0, w1, w2);
        longint          dotp, c0, c1, c2, x, y, z, t, xs, ys;
        longint unsigned cc;
        dotp = u0 * w0 + u1 * w1 + u2 * w2;
        c0   = u1 * w2 - u2 * w1;
        c1   = u2 * w0 - u0 * w2;
        c2   = u0 * w1 - u1 * w0;
        cc   = longint'(c0 * c0) + longint'(c1 * c1) + longint'(c2 * c2);
        x    = dotp;
        y    = longint'(int_sqrt(cc));
        z    = 0;
        if (x < 0) begin
            t = x;
            x = y;
            y = -t;
            z = HALF_PI_FIX;
        end
        for (int i = 0; i < 24; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x = x + ys;
                y = y - xs;
                z = z + rot_angle[i];
            end else begin
                x = x - ys;
                y = y + xs;
                z = z - rot_angle[i];
            end
        end
        if (z < 0) z = 0;
        if (z > PI_FIX) z = PI_FIX;
        return z[31:0];
    endfunction

    function automatic void accumulate(input int p, input logic [31:0] ang);
        logic [32:0] s;
        s = {1'b0, corner_sums[p]} + {1'b0, ang};
        corner_sums[p] = s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    // Returns 1 when the face adds its three angles, 0 when it is degenerate.
    function automatic bit add_face(input int a, b, c);
        longint  e1 [3], e2 [3], e3 [3];
        longint  n1 [3], n2 [3], n3 [3];
        logic [31:0] ang_a, ang_b, ang_c;
        for (int i = 0; i < 3; i++) begin
            e1[i] = point_xyz[b][i] - point_xyz[a][i];
            e2[i] = point_xyz[c][i] - point_xyz[a][i];
            e3[i] = point_xyz[c][i] - point_xyz[b][i];
        end
        if (!scale_side(e1[0], e1[1], e1[2], n1[0], n1[1], n1[2])) return 0;
        if (!scale_side(e2[0], e2[1], e2[2], n2[0], n2[1], n2[2])) return 0;
        if (!scale_side(e3[0], e3[1], e3[2], n3[0], n3[1], n3[2])) return 0;
        ang_a = interior_angle(n1[0], n1[1], n1[2], n2[0], n2[1], n2[2]);
        ang_b = interior_angle(-n1[0], -n1[1], -n1[2], n3[0], n3[1], n3[2]);
        ang_c = interior_angle(-n2[0], -n2[1], -n2[2], -n3[0], -n3[1], -n3[2]);
        accumulate(a, ang_a);
        accumulate(b, ang_b);
        accumulate(c, ang_c);
        return 1;
    endfunction

    // Applies one accepted item to the predicted state and returns its result.
    function automatic outcome_t apply_item(input logic [1:0] kind, input logic [11:0] idx,
                                            input logic signed [23:0] x, y, z,
                                            input logic [11:0] a, b, c);
        outcome_t r;
        r = '{32'd0, 1'b0, 1'b0};
        case (kind)
            KIND_LOAD: begin
                point_xyz[idx][0] = x;
                point_xyz[idx][1] = y;
                point_xyz[idx][2] = z;
                corner_sums[idx]  = 32'd0;
            end
            KIND_FACE: begin
                r.degenerate = !add_face(a, b, c);
            end
            KIND_QUERY: begin
                r.angle_sum = corner_sums[idx];
                r.is_edge   = corner_sums[idx] < threshold;
            end
            default: ;
        endcase
        return r;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Result side: stalls at random while idling is on, otherwise always ready.
    always @(posedge aclk) begin
        if (!aresetn)
            m_ready <= 1'b0;
        else
            m_ready <= idling_on ? ($urandom_range(99) >= 37) : 1'b1;
    end

    // Scoreboard. Input transfers are predicted before results are checked, both from
    // the values that stood just before this edge.
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t exp_r;
        typed_t   row;
        if (aresetn && s_valid && s_ready) begin
            exp_r = apply_item(s_kind, s_point_index, s_coord_x, s_coord_y, s_coord_z,
                               s_vertex_a, s_vertex_b, s_vertex_c);
            row = typed_rows.pop_front();
            if (row.fixed) exp_r = row.want;
            pending_results.push_back(exp_r);
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no result expected");
                error_count++;
            end else begin
                exp_r = pending_results.pop_front();
                got   = '{m_angle_sum, m_is_edge, m_degenerate};
                if (got.angle_sum !== exp_r.angle_sum) begin
                    $error("angle_sum: expected %0d, got %0d", exp_r.angle_sum, got.angle_sum);
                    error_count++;
                end
                if (got.is_edge !== exp_r.is_edge) begin
                    $error("is_edge: expected %0d, got %0d", exp_r.is_edge, got.is_edge);
                    error_count++;
                end
                if (got.degenerate !== exp_r.degenerate) begin
                    $error("degenerate: expected %0d, got %0d",
                           exp_r.degenerate, got.degenerate);
                    error_count++;
                end
            end
        end
    end

    // Offers one item and returns at the edge where it is transferred. Valid is only
    // lowered when a gap is taken, so back-to-back items keep it high.
    task automatic offer(input stim_row_t it);
        if (idling_on && $urandom_range(99) < 37) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < 37);
        end
        typed_rows.push_back('{it.fixed, it.want});
        s_valid       <= 1'b1;
        s_kind        <= it.kind;
        s_point_index <= it.idx;
        s_coord_x     <= it.x;
        s_coord_y     <= it.y;
        s_coord_z     <= it.z;
        s_vertex_a    <= it.a;
        s_vertex_b    <= it.b;
        s_vertex_c    <= it.c;
        do @(posedge aclk); while (!s_ready);
        if (it.kind == KIND_LOAD && !loaded[it.idx]) begin
            loaded[it.idx] = 1'b1;
            loaded_list.push_back(int'(it.idx));
        end
    endtask

    // Waits for every outstanding result, then writes the threshold while the block is idle.
    task automatic write_threshold(input logic [31:0] value);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        threshold = value;
    endtask

    function automatic logic signed [23:0] rand_coord();
        logic signed [23:0] v;
        v = 24'($urandom);
        return v >>> $urandom_range(23);
    endfunction

    function automatic logic [11:0] pick_loaded();
        return 12'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
    endfunction

    // Random item with well-formed content: faces and most queries name loaded points.
    function automatic stim_row_t random_item();
        stim_row_t it;
        int        sel;
        it = '{2'($urandom), 12'($urandom), rand_coord(), rand_coord(), rand_coord(),
               12'($urandom), 12'($urandom), 12'($urandom), 1'b0, '{0, 0, 0}};
        sel = $urandom_range(99);
        if (sel < 30) begin
            it.kind = KIND_LOAD;
            if ($urandom_range(3) != 0) it.idx = 12'($urandom_range(47));
            // A position copied from the first loaded point makes faces through both points degenerate.
            if ($urandom_range(9) == 0) begin
                it.idx = pick_loaded();
                it.idx = ($urandom_range(1) == 0) ? it.idx : 12'($urandom_range(47));
                it.x = 24'(point_xyz[loaded_list[0]][0]);
                it.y = 24'(point_xyz[loaded_list[0]][1]);
                it.z = 24'(point_xyz[loaded_list[0]][2]);
            end
        end else if (sel < 70) begin
            it.kind = KIND_FACE;
            it.a = pick_loaded();
            it.b = pick_loaded();
            it.c = pick_loaded();
        end else if (sel < 96) begin
            it.kind = KIND_QUERY;
            if ($urandom_range(4) != 0) it.idx = pick_loaded();
        end else begin
            it.kind = KIND_NONE;
        end
        return it;
    endfunction

    localparam logic signed [23:0] CMAX = 24'sh7FFFFF;
    localparam logic signed [23:0] CMIN = -24'sh800000;

    stim_row_t directed [18] = '{
        // A point never loaded reads back zero and counts as an edge point.
        '{KIND_QUERY, 12'd5, 0, 0, 0, 0, 0, 0, 1'b1, '{32'd0, 1'b1, 1'b0}},
        // The unused kind leaves everything alone and returns all zero.
        '{KIND_NONE, 12'hFFF, -1, -1, -1, 12'hFFF, 12'hFFF, 12'hFFF, 1'b1, '{0, 0, 0}},
        '{KIND_LOAD, 12'd0, 0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_LOAD, 12'd1, CMAX, CMAX, CMAX, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_LOAD, 12'hFFF, CMIN, CMIN, CMIN, 0, 0, 0, 1'b1, '{0, 0, 0}},
        // Collinear corners with the widest coordinate differences.
        '{KIND_FACE, 0, 0, 0, 0, 12'd0, 12'd1, 12'hFFF, 1'b0, '{0, 0, 0}},
        // A corner named twice gives a zero-length side.
        '{KIND_FACE, 0, 0, 0, 0, 12'd0, 12'd0, 12'd1, 1'b1, '{0, 0, 1'b1}},
        '{KIND_LOAD, 12'd2, 1, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_LOAD, 12'd3, 0, 1, 0, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_FACE, 0, 0, 0, 0, 12'd0, 12'd2, 12'd3, 1'b0, '{0, 0, 0}},
        '{KIND_QUERY, 12'd0, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}},
        '{KIND_QUERY, 12'd2, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}},
        '{KIND_QUERY, 12'hFFF, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}},
        // Two distinct points at the same position.
        '{KIND_LOAD, 12'd5, 1, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_FACE, 0, 0, 0, 0, 12'd2, 12'd5, 12'd3, 1'b1, '{0, 0, 1'b1}},
        // Reloading a point clears its sum.
        '{KIND_LOAD, 12'd0, 0, 0, 0, 0, 0, 0, 1'b1, '{0, 0, 0}},
        '{KIND_QUERY, 12'd0, 0, 0, 0, 0, 0, 0, 1'b1, '{32'd0, 1'b1, 1'b0}},
        '{KIND_QUERY, 12'd1, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}}
    };

    logic [31:0] phase_thresholds [4] = '{32'hFFFF_FFFF, 32'd0, 32'd0, THRESHOLD_RESET};

    initial begin
        aresetn       = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_kind        = KIND_LOAD;
        s_point_index = '0;
        s_coord_x     = '0;
        s_coord_y     = '0;
        s_coord_z     = '0;
        s_vertex_a    = '0;
        s_vertex_b    = '0;
        s_vertex_c    = '0;
        idling_on     = 1'b1;
        error_count   = 0;
        threshold     = THRESHOLD_RESET;
        for (int i = 0; i < NPTS; i++) begin
            corner_sums[i] = 32'd0;
            loaded[i]      = 1'b0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed[i]) offer(directed[i]);

        phase_thresholds[2] = $urandom_range(32'd120_000_000, 32'd20_000_000);
        for (int ph = 0; ph < 4; ph++) begin
            write_threshold(phase_thresholds[ph]);
            // The third phase runs with no gaps and no stalls at all.
            idling_on = (ph != 2);
            for (int n = 0; n < 185; n++) offer(random_item());
        end
        idling_on = 1'b1;

        // Drive one point's sum into saturation with flat faces that give it pi each time.
        write_threshold(32'hFFFF_FFFF);
        offer('{KIND_LOAD, 12'd4000, 0, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}});
        offer('{KIND_LOAD, 12'd4001, 5, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}});
        offer('{KIND_LOAD, 12'd4002, 9, 0, 0, 0, 0, 0, 1'b0, '{0, 0, 0}});
        for (int n = 0; n < 84; n++)
            offer('{KIND_FACE, 0, 0, 0, 0, 12'd4000, 12'd4001, 12'd4002, 1'b0, '{0, 0, 0}});
        offer('{KIND_QUERY, 12'd4001, 0, 0, 0, 0, 0, 0, 1'b1,
                '{32'hFFFF_FFFF, 1'b0, 1'b0}});

        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (300) @(posedge aclk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    // Backstop against a hung handshake, far beyond the slowest correct run.
    initial begin
        #40ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ files.f @@
rtl/mvas_pkg.sv
rtl/mvas_ram.sv
rtl/mvas_corner_angle.sv
rtl/mesh_vertex_angle_sum_edge_detect.sv
tb/testbench.sv
